// ----- rtl/sdzc_pkg.sv -----
// ----------------------------------------------------------------------------
// Shower depth correction package
// Shared types, constants and field widths for the depth correction pipeline.
// ----------------------------------------------------------------------------
package sdzc_pkg;

    localparam int unsigned D8          = 99920;
    localparam int unsigned D8_SQ_W     = 34;
    localparam logic [33:0] D8_SQ       = 34'd9984006400;
    localparam logic [22:0] LOG2_1000   = 23'd653118;
    localparam logic [15:0] LN2_Q16     = 16'd45426;
    localparam int          Z_MAX       = 524287;
    localparam int          Z_MIN       = -524288;

    localparam int unsigned SQRT_STEPS  = 18;  // result bits of sqrt(r2), r2 < 2^35
    localparam int unsigned LOG_STEPS   = 16;  // fraction bits of log2
    localparam int unsigned DIV_STEPS   = 17;  // quotient bits of c, c <= 65536

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_E_ZERO   = 2'd1,
        ST_X_ZERO   = 2'd2,
        ST_Y_ZERO   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_ZREF  = 2'd0,
        REG_ZSS   = 2'd1,
        REG_SLOPE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [23:0]        energy_mev;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] depth_z;
        logic [1:0]         status;
    } t_out_item;

    // Data handed from cell to cell along the chain.
    typedef struct packed {
        logic        vld;
        logic [1:0]  status;
        // square root (restoring, one root bit a step)
        logic [35:0] sq_rem;
        logic [35:0] sq_val;
        logic [17:0] sq_res;
        // log2 (squaring, one fraction bit a step)
        logic [30:0] lg_m;
        logic [4:0]  lg_p;
        logic [15:0] lg_frac;
    } t_cell_data;

    // Data for the divider chain.
    typedef struct packed {
        logic        vld;
        logic [1:0]  status;
        logic [17:0] den;
        logic [17:0] rem;
        logic [16:0] quo;
        logic [20:0] lg;
    } t_div_data;

endpackage

// ----- rtl/sdzc_cell.sv -----
// ----------------------------------------------------------------------------
// Shower depth cell
// One step of the square root and one step of the log2 squaring.
// ----------------------------------------------------------------------------
module sdzc_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdzc_pkg::t_cell_data i_d,
    output sdzc_pkg::t_cell_data o_d
);
    import sdzc_pkg::*;

    // Fraction bit settled by this cell; cells past the log steps set none.
    localparam int unsigned FRAC_BIT = (STEP < LOG_STEPS) ? LOG_STEPS - 1 - STEP : 0;

    t_cell_data  r_d, n_d;
    logic [35:0] w_bit;
    logic [35:0] w_trial;
    logic [61:0] w_sq;
    logic [31:0] w_m;

    always_comb begin
        n_d = i_d;
        // square root: bit weight 4^(17-STEP)
        w_bit   = 36'd1 << (2 * (SQRT_STEPS - 1 - STEP));
        w_trial = i_d.sq_val + w_bit;
        if (STEP < SQRT_STEPS) begin
            if (i_d.sq_rem >= w_trial) begin
                n_d.sq_rem = i_d.sq_rem - w_trial;
                n_d.sq_val = (i_d.sq_val >> 1) + w_bit;
            end else begin
                n_d.sq_val = i_d.sq_val >> 1;
            end
        end
        // log2: one fraction bit
        w_sq = {31'd0, i_d.lg_m} * {31'd0, i_d.lg_m};
        w_m  = w_sq[61:30];
        if (STEP < LOG_STEPS) begin
            if (w_m[31]) begin
                n_d.lg_m = w_m[31:1];
                n_d.lg_frac[FRAC_BIT] = 1'b1;
            end else begin
                n_d.lg_m = w_m[30:0];
            end
        end
        n_d.sq_res = n_d.sq_val[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
        r_d.status  <= n_d.status;
        r_d.sq_rem  <= n_d.sq_rem;
        r_d.sq_val  <= n_d.sq_val;
        r_d.sq_res  <= n_d.sq_res;
        r_d.lg_m    <= n_d.lg_m;
        r_d.lg_p    <= n_d.lg_p;
        r_d.lg_frac <= n_d.lg_frac;
    end

    assign o_d = r_d;

endmodule

// ----- rtl/sdzc_div_cell.sv -----
// ----------------------------------------------------------------------------
// Shower depth divider cell
// One restoring division step of 99920 * 2^16 / s.
// ----------------------------------------------------------------------------
module sdzc_div_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdzc_pkg::t_div_data  i_d,
    output sdzc_pkg::t_div_data  o_d
);
    import sdzc_pkg::*;

    localparam logic [32:0] NUM = 33'(D8) << 16;

    t_div_data   r_d, n_d;
    logic [18:0] w_try;

    always_comb begin
        n_d   = i_d;
        w_try = {i_d.rem, NUM[DIV_STEPS - 1 - STEP]};
        if (w_try >= {1'b0, i_d.den}) begin
            n_d.rem = 18'(w_try - {1'b0, i_d.den});
            n_d.quo = {i_d.quo[15:0], 1'b1};
        end else begin
            n_d.rem = w_try[17:0];
            n_d.quo = {i_d.quo[15:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
        r_d.status <= n_d.status;
        r_d.den    <= n_d.den;
        r_d.rem    <= n_d.rem;
        r_d.quo    <= n_d.quo;
        r_d.lg     <= n_d.lg;
    end

    assign o_d = r_d;

endmodule

// ----- rtl/shower_depth_z_correction.sv -----
// ----------------------------------------------------------------------------
// Shower depth z correction
// Pipelined depth correction of calorimeter clusters, one cluster a cycle.
// ----------------------------------------------------------------------------
// Usage: raise i_start with a cluster request on i_in; it is taken at any
// clock edge where o_busy is low, and o_busy is always low, so a new request
// may follow in every cycle. The corrected depth appears on o_out with
// o_done high for exactly one cycle after the request has passed the input
// register, eighteen square root and log2 cells, seventeen divider cells,
// the ln, bracket and product registers and a rounding and clamping
// register; the input preparation is registered at the edge that takes
// the request. Throughput is one request a cycle. The receiver cannot
// stall the block, so results must be taken as they come. The user must
// write configuration through i_cfg_valid/o_cfg_ready only while the block
// is idle; the block itself does not enforce this. Unknown indexes are
// ignored. A synchronous reset restores the default register values and empties the pipeline.
// ----------------------------------------------------------------------------
module shower_depth_z_correction (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  sdzc_pkg::t_in_item   i_in,
    output logic                 o_done,
    output sdzc_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [18:0]          i_cfg_data
);
    import sdzc_pkg::*;

    // Configuration registers.
    logic [18:0] r_zref;
    logic [15:0] r_zss;
    logic [15:0] r_slope;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zref  <= 19'd199680;
            r_zss   <= 16'd2738;
            r_slope <= 16'd2488;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ZREF:  r_zref  <= i_cfg_data;
                REG_ZSS:   r_zss   <= i_cfg_data[15:0];
                REG_SLOPE: r_slope <= i_cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Input preparation: squares, status and log normalisation.
    t_cell_data n_head, r_head;
    logic [31:0] w_xx, w_yy;
    logic [4:0]  w_p;
    logic [53:0] w_mshift;

    always_comb begin
        w_xx = 32'($signed(i_in.pos_x) * $signed(i_in.pos_x));
        w_yy = 32'($signed(i_in.pos_y) * $signed(i_in.pos_y));
        w_p  = 5'd0;
        for (int i = 1; i < 24; i++) begin
            if (i_in.energy_mev[i]) begin
                w_p = 5'(i);
            end
        end
        w_mshift = {30'd0, i_in.energy_mev} << (5'd30 - w_p);
        n_head         = '0;
        n_head.vld     = i_start & ~o_busy;
        n_head.status  = (i_in.energy_mev == '0) ? ST_E_ZERO :
                         (i_in.pos_x == '0)      ? ST_X_ZERO :
                         (i_in.pos_y == '0)      ? ST_Y_ZERO : ST_OK;
        n_head.sq_rem  = {4'd0, w_xx} + {4'd0, w_yy} + {2'd0, D8_SQ};
        n_head.lg_m    = w_mshift[30:0];
        n_head.lg_p    = w_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else begin
            r_head.vld <= n_head.vld;
        end
        r_head.status  <= n_head.status;
        r_head.sq_rem  <= n_head.sq_rem;
        r_head.sq_val  <= n_head.sq_val;
        r_head.sq_res  <= n_head.sq_res;
        r_head.lg_m    <= n_head.lg_m;
        r_head.lg_p    <= n_head.lg_p;
        r_head.lg_frac <= n_head.lg_frac;
    end

    // Chain of root/log cells; each does one root bit and one log bit.
    t_cell_data w_chain [SQRT_STEPS + 1];
    assign w_chain[0] = r_head;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
        sdzc_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g + 1])
        );
    end

    // Divider chain for c = 99920 * 2^16 / s.
    t_div_data w_div [DIV_STEPS + 1];
    t_cell_data w_tail;
    assign w_tail = w_chain[SQRT_STEPS];

    // The root is never below 99920, so the upper sixteen numerator bits
    // give no quotient bits and simply leave 99920 / 2 as the remainder
    // that the first divider cell starts from.
    always_comb begin
        w_div[0]        = '0;
        w_div[0].vld    = w_tail.vld;
        w_div[0].status = w_tail.status;
        w_div[0].den    = (w_tail.sq_res == '0) ? 18'd1 : w_tail.sq_res;
        w_div[0].rem    = 18'(D8 >> 1);
        w_div[0].lg     = {w_tail.lg_p, w_tail.lg_frac};
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        sdzc_div_cell #(.STEP(g)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_div[g]),
            .o_d     (w_div[g + 1])
        );
    end

    t_div_data w_dq;
    assign w_dq = w_div[DIV_STEPS];

    // Back end: ln, bracket, product, round and clamp, with a register
    // after each multiplication, add and shift.
    logic [6:0]  r_v;
    logic [1:0]  r_st [7];
    logic [16:0] r_c  [5];
    logic signed [21:0] r_dl;      // log2E - log2(1000), Q16
    logic signed [38:0] r_lnp;     // dl * ln2
    logic signed [22:0] r_ln;      // ln, Q16
    logic signed [39:0] r_lslope;  // slope * ln
    logic signed [40:0] r_b;       // bracket
    logic signed [52:0] r_bc_lo_full;  // b * c[11:0]
    logic signed [45:0] r_bc_hi;   // b * c[16:12]
    logic signed [58:0] r_bc;
    t_out_item          r_out;

    logic signed [52:0] w_bc_lo;
    logic signed [45:0] w_bc_hi;
    logic signed [58:0] w_sum;
    logic signed [22:0] w_t;
    logic signed [23:0] w_z;

    assign w_bc_lo = r_b * $signed({1'b0, r_c[4][11:0]});
    assign w_bc_hi = r_b * $signed({1'b0, r_c[4][16:12]});
    assign w_sum   = $signed(59'(r_bc)) + $signed(59'(60'sd1 <<< 35));
    assign w_t     = 23'(w_sum >>> 36);
    assign w_z     = $signed({5'd0, r_zref}) + 24'(w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], w_dq.vld};
        end
        r_st[0] <= w_dq.status;
        for (int i = 1; i < 7; i++) begin
            r_st[i] <= r_st[i - 1];
        end
        r_c[0] <= w_dq.quo;
        for (int i = 1; i < 5; i++) begin
            r_c[i] <= r_c[i - 1];
        end
        // stage 1
        r_dl     <= 22'($signed({1'b0, w_dq.lg}) - $signed({2'b0, LOG2_1000}));
        // stage 2
        r_lnp    <= r_dl * $signed({1'b0, LN2_Q16});
        // stage 3
        r_ln     <= 23'(r_lnp >>> 16);
        // stage 4
        r_lslope <= r_ln * $signed({1'b0, r_slope});
        // stage 5
        r_b      <= $signed({5'd0, r_zss, 20'd0}) + 41'(r_lslope);
        // stage 6 (split product)
        r_bc_lo_full <= w_bc_lo;
        r_bc_hi      <= w_bc_hi;
        // stage 7
        r_bc     <= 59'(r_bc_lo_full) + (59'(r_bc_hi) <<< 12);
        // output: round, add the reference depth and clamp, or zero on error
        if (!r_v[6] || r_st[6] != ST_OK) begin
            r_out.depth_z <= '0;
        end else if (w_z > 24'sd524287) begin
            r_out.depth_z <= 20'sh7FFFF;
        end else if (w_z < -24'sd524288) begin
            r_out.depth_z <= 20'sh80000;
        end else begin
            r_out.depth_z <= w_z[19:0];
        end
        r_out.status <= r_st[6];
    end

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v[6];
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    a_busy_low: assert property (@(posedge i_clk) o_busy == 1'b0)
        else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head.vld |-> ##43 o_done)
        else $error("result missing");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status != ST_OK) |-> o_out.depth_z == '0)
        else $error("error result not zero");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shower depth z correction testbench
// Drives cluster requests with random gaps, predicts each corrected depth
// with an independent fixed-point model and checks every strobed result.
// ----------------------------------------------------------------------------
module testbench;
    import sdzc_pkg::*;

    // The drain covers the full pipeline with room to spare.
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_LIMIT   = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_in;
    logic        o_done;
    t_out_item   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [18:0] i_cfg_data;

    shower_depth_z_correction i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copies of the configuration registers.
    logic [18:0] zref_q;
    logic [15:0] zss_q;
    logic [15:0] slope_q;

    t_out_item   depth_queue[$];
    int          error_count;
    int          request_count;
    int          result_count;
    int          idle_cycles;
    bit          gaps_enabled;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Integer square root by the restoring bit method.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        begin
            res   = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        end
    endfunction

    // log2 of a nonzero energy in Q16, one fraction bit per squaring.
    function automatic longint log2_energy(input logic [23:0] e);
        int              p;
        longint unsigned m;
        longint unsigned frac;
        begin
            p    = 0;
            frac = 0;
            while (p < 23 && (e >> (p + 1)) != 0) p++;
            m = longint'(e) << (30 - p);
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    m    = m >> 1;
                    frac = frac | (64'd1 << (15 - i));
                end
            end
            return (longint'(p) << 16) | longint'(frac);
        end
    endfunction

    // Arithmetic shift right is a floor division for signed operands.
    function automatic t_out_item predict_depth(input t_in_item item);
        t_out_item       res;
        longint          x;
        longint          y;
        longint unsigned s;
        longint unsigned c;
        longint          ln_q;
        longint          bracket;
        longint          term;
        longint          z;
        begin
            x = item.pos_x;
            y = item.pos_y;
            res.depth_z = '0;
            if (item.energy_mev == 0) begin
                res.status = ST_E_ZERO;
            end else if (x == 0) begin
                res.status = ST_X_ZERO;
            end else if (y == 0) begin
                res.status = ST_Y_ZERO;
            end else begin
                s = int_sqrt(longint'(x * x + y * y) + 64'd99920 * 64'd99920);
                c = (64'd99920 << 16) / s;
                ln_q = ((log2_energy(item.energy_mev) - 653118) * 45426) >>> 16;
                bracket = (longint'(zss_q) <<< 20) + longint'(slope_q) * ln_q;
                term = (bracket * longint'(c) + (64'sd1 <<< 35)) >>> 36;
                z = longint'(zref_q) + term;
                if (z > Z_MAX) z = Z_MAX;
                if (z < Z_MIN) z = Z_MIN;
                res.depth_z = z[19:0];
                res.status  = ST_OK;
            end
            return res;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                     what, got, want, result_count);
            error_count++;
        end
    endtask

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (depth_queue.size() == 0) begin
                report_mismatch("unexpected result", o_out.depth_z, 0);
            end else begin
                want = depth_queue.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", o_out.status, want.status);
                if (o_out.depth_z !== want.depth_z)
                    report_mismatch("depth_z", o_out.depth_z, want.depth_z);
            end
            result_count++;
        end
    end

    // Watchdog: counts cycles in which no request, write or result moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("shower_depth_z_correction: mismatch");
            $finish;
        end
    end

    // Within a run, start is dropped only when a gap is taken, so requests
    // without a gap follow each other in consecutive cycles.
    task automatic random_gap();
        int n;
        begin
            if (gaps_enabled && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 18);
                i_start <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    // Sends one cluster request and records its expected depth.
    task automatic send_cluster(input t_in_item item);
        begin
            random_gap();
            i_start <= 1'b1;
            i_in    <= item;
            @(posedge i_clk);
            while (o_busy) @(posedge i_clk);
            depth_queue.push_back(predict_depth(item));
            request_count++;
        end
    endtask

    task automatic wait_drained();
        begin
            i_start <= 1'b0;
            while (depth_queue.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    // Writes one register while the pipeline is empty; unknown indexes are
    // left out of the shadow copy just as the block ignores them.
    task automatic write_register(input logic [1:0] idx, input logic [18:0] value);
        begin
            wait_drained();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= value;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            i_cfg_valid <= 1'b0;
            case (idx)
                REG_ZREF:  zref_q  = value;
                REG_ZSS:   zss_q   = value[15:0];
                REG_SLOPE: slope_q = value[15:0];
                default: begin
                end
            endcase
        end
    endtask

    function automatic t_in_item make_cluster(input logic [23:0] e,
                                              input logic [15:0] x,
                                              input logic [15:0] y);
        t_in_item item;
        begin
            item.energy_mev = e;
            item.pos_x      = x;
            item.pos_y      = y;
            return item;
        end
    endfunction

    // Random energy spread over every magnitude, with zeros now and then.
    function automatic logic [23:0] random_energy();
        logic [23:0] e;
        begin
            e = 24'($urandom);
            e = e >> $urandom_range(0, 23);
            if ($urandom_range(0, 40) == 0) e = 0;
            return e;
        end
    endfunction

    function automatic logic [15:0] random_position();
        logic [15:0] v;
        begin
            v = 16'($urandom);
            case ($urandom_range(0, 9))
                0: v = 0;
                1: v = 16'h8000;
                2: v = 16'h7FFF;
                3: v = v >>> $urandom_range(4, 15);
                default: begin
                end
            endcase
            return v;
        end
    endfunction

    // Edge values of every field and each error status, including the order
    // of precedence when several fields are zero at once.
    task automatic test_directed();
        begin
            send_cluster(make_cluster(24'd0, 16'd100, 16'd100));
            send_cluster(make_cluster(24'd0, 16'd0, 16'd0));
            send_cluster(make_cluster(24'd5000, 16'd0, 16'd0));
            send_cluster(make_cluster(24'd5000, 16'd0, 16'd7));
            send_cluster(make_cluster(24'd5000, 16'd7, 16'd0));
            send_cluster(make_cluster(24'd1, 16'd1, 16'd1));
            send_cluster(make_cluster(24'hFFFFFF, 16'h7FFF, 16'h7FFF));
            send_cluster(make_cluster(24'hFFFFFF, 16'h8000, 16'h8000));
            send_cluster(make_cluster(24'd1000, 16'hFFFF, 16'h0001));
            send_cluster(make_cluster(24'd999, 16'h8000, 16'h7FFF));
            send_cluster(make_cluster(24'd1001, 16'h1234, 16'hEDCC));
            send_cluster(make_cluster(24'h800000, 16'h0400, 16'hFC00));
            send_cluster(make_cluster(24'h7FFFFF, 16'hAAAA, 16'h5555));
            send_cluster(make_cluster(24'd2, 16'h5555, 16'hAAAA));
        end
    endtask

    task automatic test_random(input int count);
        begin
            for (int i = 0; i < count; i++)
                send_cluster(make_cluster(random_energy(), random_position(),
                                          random_position()));
        end
    endtask

    // Extreme register settings reach the upper bound and negative depths.
    task automatic test_config_extremes();
        begin
            write_register(REG_ZREF, 19'h7FFFF);
            write_register(REG_ZSS, 19'hFFFF);
            write_register(REG_SLOPE, 19'hFFFF);
            test_directed();
            test_random(100);
            write_register(REG_ZREF, 19'd0);
            write_register(REG_ZSS, 19'd0);
            write_register(REG_SLOPE, 19'hFFFF);
            test_directed();
            test_random(100);
            write_register(REG_SLOPE, 19'd0);
            test_random(60);
            write_register(2'd3, 19'h12345);
            test_random(40);
        end
    endtask

    task automatic test_config_random();
        begin
            for (int k = 0; k < 4; k++) begin
                write_register(REG_ZREF, 19'($urandom));
                write_register(REG_ZSS, 19'($urandom));
                write_register(REG_SLOPE, 19'($urandom));
                test_random(120);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_in         = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_ZREF;
        i_cfg_data   = '0;
        zref_q       = 19'd199680;
        zss_q        = 16'd2738;
        slope_q      = 16'd2488;
        error_count  = 0;
        request_count = 0;
        result_count = 0;
        idle_cycles  = 0;
        gaps_enabled = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first, then corner settings, then random settings.
        test_directed();
        test_random(300);
        test_config_extremes();
        test_config_random();
        // The last stretch runs back to back at the full request rate.
        gaps_enabled = 1'b0;
        test_random(200);
        wait_drained();

        $display("Sent %0d cluster requests and checked %0d results", request_count,
                 result_count);
        $display("over reset, extreme and random register settings.");
        if (error_count == 0 && depth_queue.size() == 0) begin
            $display("shower_depth_z_correction: match");
        end else begin
            $display("shower_depth_z_correction: mismatch");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/sdzc_pkg.sv
rtl/sdzc_cell.sv
rtl/sdzc_div_cell.sv
rtl/shower_depth_z_correction.sv
tb/sv/testbench.sv
